// ----- hw/rtl/lookahead_prefetch_priority_queue_macros.svh -----
// Assertion macros for the prefetch priority queue.
// No dependencies; included by the top level.
`ifndef LOOKAHEAD_PREFETCH_PRIORITY_QUEUE_MACROS_SVH
`define LOOKAHEAD_PREFETCH_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define LPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/lpq_pkg.sv -----
// Shared types and codes of the prefetch priority queue.
// No dependencies.
package lpq_pkg;
	typedef enum logic [2:0] {
		FN_LAYER_START = 3'd0, FN_PAGE_ACCESS = 3'd1, FN_REQ_LAYER = 3'd2,
		FN_REQ_PAGE = 3'd3, FN_DEQUEUE = 3'd4, FN_REPORT = 3'd5, FN_CANCEL = 3'd6
	} func_t;

	localparam logic [2:0] ST_QUEUED    = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DISABLED  = 3'd2;
	localparam logic [2:0] ST_DEQUEUED  = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_CANCELLED = 3'd5;
	localparam logic [2:0] ST_COUNTED   = 3'd6;

	localparam logic [2:0] CFG_ENABLE = 3'd0;
	localparam logic [2:0] CFG_AUTO   = 3'd1;
	localparam logic [2:0] CFG_LAYER  = 3'd2;
	localparam logic [2:0] CFG_PAGE   = 3'd3;
	localparam logic [2:0] CFG_LIMIT  = 3'd4;

	// Operation handed from the front to the back.
	typedef enum logic [2:0] {
		OP_INSERT = 3'd0, OP_DEQ = 3'd1, OP_REPORT = 3'd2, OP_CANCEL = 3'd3,
		OP_REJECT = 3'd4
	} op_t;

	typedef struct packed {
		op_t          op;
		logic         kind;
		logic [31:0]  id;
		logic [15:0]  prio;
		logic         success;
		logic         last;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        kind;
		logic [31:0] id;
		logic [15:0] prio;
		logic        last;
	} res_t;
endpackage

// ----- hw/rtl/lookahead_prefetch_priority_queue.sv -----
// Prefetch request engine: lookahead expansion in front, sorted queue in back.
// A request, dequeue, report or cancel result is loaded into the result register after
// its command passes the command queue; a lookahead result also after the walk register.
// Throughput: one insert per cycle unless the command queue is full; a lookahead item
// holds the input while its targets are walked (up to MAX_LOOKAHEAD, ending early on
// wrap). Result stalls back up through the two-entry command queue. Reset (arst_n low,
// asynchronous): queue empty, marks and counters zero, registers to their defaults.
`include "lookahead_prefetch_priority_queue_macros.svh"
module lookahead_prefetch_priority_queue import lpq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_LOOKAHEAD = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [31:0] target_id,
	input  logic signed [15:0] req_priority,
	input  logic        success,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        kind,
	output logic [31:0] request_id,
	output logic signed [15:0] request_priority,
	output logic        last,
	output logic [4:0]  pending,
	output logic [31:0] completed,
	output logic [31:0] failed
);
	logic enable_q, auto_q;
	logic [4:0] layer_la_q, page_la_q, limit_q;

	// config writes always taken
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1; auto_q <= 1'b1; layer_la_q <= 5'd2;
			page_la_q <= 5'd4; limit_q <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_AUTO:   auto_q <= cfg_data[0];
				CFG_LAYER:  layer_la_q <= cfg_data;
				CFG_PAGE:   page_la_q <= cfg_data;
				CFG_LIMIT:  limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// two-entry command queue between front and back
	cmd_t f_cmd, q_mem_q [2];
	logic f_valid, q_full, b_ready;
	logic [1:0] q_cnt_q;
	logic q_rd_q, q_wr_q;
	assign q_full = q_cnt_q == 2'd2;

	lpq_front #(.MAX_LOOKAHEAD(MAX_LOOKAHEAD)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .target_id,
		.req_priority(req_priority), .success, .enable(enable_q),
		.auto_en(auto_q), .layer_lookahead(layer_la_q),
		.page_lookahead(page_la_q), .cmd_valid(f_valid), .cmd_full(q_full),
		.cmd(f_cmd)
	);

	logic q_pop, q_push;
	assign q_push = f_valid;
	assign q_pop = (q_cnt_q != 2'd0) && b_ready;
	always_ff @(posedge clk) if (q_push) q_mem_q[q_wr_q] <= f_cmd;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0; q_rd_q <= 1'b0; q_wr_q <= 1'b0;
		end else begin
			if (q_push) q_wr_q <= !q_wr_q;
			if (q_pop) q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(q_push) - 2'(q_pop);
		end
	end

	// the front marks last on the final issued lookahead target
	res_t res;
	lpq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid(q_cnt_q != 2'd0), .cmd_ready(b_ready),
		.cmd(q_mem_q[q_rd_q]), .enable(enable_q), .queue_limit(limit_q),
		.out_valid, .out_stall, .res, .pending, .completed, .failed
	);
	assign status = res.status;
	assign kind = res.kind;
	assign request_id = res.id;
	assign request_priority = res.prio;
	assign last = res.last;

	`LPQ_ASSERT_IMPL(a_no_overflow, clk, arst_n, 1'b1, q_cnt_q <= 2'd2)
	`LPQ_ASSERT_NEXT(a_cancel_clears, clk, arst_n,
		q_pop && q_mem_q[q_rd_q].op == OP_CANCEL, pending == 5'd0)
	`LPQ_ASSERT_IMPL(a_pending_bound, clk, arst_n, out_valid,
		32'(pending) <= QUEUE_DEPTH)
endmodule

// ----- hw/rtl/lpq_front.sv -----
// Front end: expands items into commands, lookahead watermarks.
// Depends on lpq_pkg.
module lpq_front import lpq_pkg::*; #(
	parameter int MAX_LOOKAHEAD = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [31:0] target_id,
	input  logic [15:0] req_priority,
	input  logic        success,
	input  logic        enable,
	input  logic        auto_en,
	input  logic [4:0]  layer_lookahead,
	input  logic [4:0]  page_lookahead,
	output logic        cmd_valid,
	input  logic        cmd_full,
	output cmd_t        cmd
);
	logic        busy_q, kind_q;
	logic [31:0] base_q;
	logic [4:0]  n_q, i_q;
	logic [31:0] layer_mark_q, page_mark_q;
	logic        layer_valid_q;
	logic [4:0]  n_sel;
	logic [31:0] tgt;
	logic        skip, final_step;
	logic        later_issue;

	always_comb begin
		n_sel = func[0] ? page_lookahead : layer_lookahead;
		if (n_sel > 5'(MAX_LOOKAHEAD)) n_sel = 5'(MAX_LOOKAHEAD);
	end

	assign tgt = base_q + 32'(i_q);
	assign skip = kind_q ? (tgt <= page_mark_q) : (layer_valid_q && tgt <= layer_mark_q);
	assign final_step = (i_q == n_q);
	assign in_stall = busy_q || cmd_full;

	// After issuing tgt the mark becomes tgt, so a later target issues unless
	// the walk ends here or the next id wraps to zero (then all the rest skip).
	assign later_issue = !final_step && (tgt != 32'hFFFF_FFFF);

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '0;
		cmd.op = OP_INSERT;
		if (busy_q) begin
			cmd.kind = kind_q;
			cmd.id = tgt;
			cmd.prio = 16'(n_q - i_q);
			cmd.last = !later_issue;
			cmd_valid = !skip && !cmd_full;
		end else if (in_valid && !cmd_full) begin
			cmd.id = target_id;
			cmd.prio = req_priority;
			cmd.success = success;
			cmd.last = 1'b1;
			case (func)
				FN_REQ_LAYER, FN_REQ_PAGE: begin
					cmd.kind = func[0];
					cmd.op = enable ? OP_INSERT : OP_REJECT;
					cmd_valid = 1'b1;
				end
				FN_DEQUEUE: begin cmd.op = OP_DEQ; cmd_valid = 1'b1; end
				FN_REPORT: begin cmd.op = OP_REPORT; cmd_valid = 1'b1; end
				FN_CANCEL: begin cmd.op = OP_CANCEL; cmd_valid = 1'b1; end
				default: cmd_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; layer_valid_q <= 1'b0;
			layer_mark_q <= '0; page_mark_q <= '0;
			kind_q <= 1'b0; base_q <= '0; n_q <= '0; i_q <= '0;
		end else if (busy_q) begin
			if (!cmd_full) begin
				if (!skip) begin
					if (kind_q) page_mark_q <= tgt;
					else begin layer_mark_q <= tgt; layer_valid_q <= 1'b1; end
				end
				if (final_step || (!skip && !later_issue)) busy_q <= 1'b0;
				i_q <= i_q + 5'd1;
			end
		end else if (in_valid && !cmd_full) begin
			if ((func == FN_LAYER_START || func == FN_PAGE_ACCESS) && enable
					&& auto_en && n_sel != 5'd0) begin
				busy_q <= 1'b1; kind_q <= func[0]; base_q <= target_id;
				n_q <= n_sel; i_q <= 5'd1;
			end
			if (func == FN_CANCEL) begin
				layer_valid_q <= 1'b0; layer_mark_q <= '0; page_mark_q <= '0;
			end
		end
	end
endmodule

// ----- hw/rtl/lpq_back.sv -----
// Back end: sorted queue, counters and result register.
// Depends on lpq_pkg.
module lpq_back import lpq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic        enable,
	input  logic [4:0]  queue_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        res,
	output logic [4:0]  pending,
	output logic [31:0] completed,
	output logic [31:0] failed
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	logic [QUEUE_DEPTH-1:0]        ekind_q;
	logic [QUEUE_DEPTH-1:0][31:0]  eid_q;
	logic [QUEUE_DEPTH-1:0][15:0]  eprio_q;
	logic [CW-1:0] count_q;
	logic [31:0] ok_q, fail_q;
	logic [4:0] lim;
	logic go, full;

	always_comb begin
		lim = queue_limit;
		if (32'(queue_limit) > QUEUE_DEPTH) lim = 5'(QUEUE_DEPTH);
	end
	assign cmd_ready = !out_valid || !out_stall;
	assign go = cmd_valid && cmd_ready;
	assign full = 32'(count_q) >= 32'(lim);

	// per slot: does it keep its priority at or above the new one
	logic [QUEUE_DEPTH-1:0] ge;
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++)
			ge[k] = (k < 32'(count_q)) && ($signed(eprio_q[k]) >= $signed(cmd.prio));
	end

	always_ff @(posedge clk) begin
		if (go && cmd.op == OP_INSERT && enable && !full) begin
			if (!ge[0]) begin
				ekind_q[0] <= cmd.kind; eid_q[0] <= cmd.id; eprio_q[0] <= cmd.prio;
			end
			for (int k = 1; k < QUEUE_DEPTH; k++) begin
				if (!ge[k]) begin
					if (ge[k-1]) begin
						ekind_q[k] <= cmd.kind; eid_q[k] <= cmd.id; eprio_q[k] <= cmd.prio;
					end else begin
						ekind_q[k] <= ekind_q[k-1]; eid_q[k] <= eid_q[k-1];
						eprio_q[k] <= eprio_q[k-1];
					end
				end
			end
		end else if (go && cmd.op == OP_DEQ && count_q != '0) begin
			for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
				ekind_q[k] <= ekind_q[k+1]; eid_q[k] <= eid_q[k+1];
				eprio_q[k] <= eprio_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; ok_q <= '0; fail_q <= '0; out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (go) begin
				out_valid <= 1'b1;
				res.last <= cmd.last;
				res.kind <= 1'b0; res.id <= '0; res.prio <= '0;
				case (cmd.op)
					OP_INSERT: begin
						res.kind <= cmd.kind; res.id <= cmd.id; res.prio <= cmd.prio;
						if (!enable) res.status <= ST_DISABLED;
						else if (full) res.status <= ST_FULL;
						else begin res.status <= ST_QUEUED; count_q <= count_q + 1'b1; end
					end
					OP_REJECT: begin
						res.kind <= cmd.kind; res.id <= cmd.id; res.prio <= cmd.prio;
						res.status <= ST_DISABLED;
					end
					OP_DEQ: begin
						if (count_q == '0) res.status <= ST_EMPTY;
						else begin
							res.status <= ST_DEQUEUED; res.kind <= ekind_q[0];
							res.id <= eid_q[0]; res.prio <= eprio_q[0];
							count_q <= count_q - 1'b1;
						end
					end
					OP_REPORT: begin
						res.status <= ST_COUNTED;
						if (cmd.success) begin
							if (ok_q != '1) ok_q <= ok_q + 32'd1;
						end else if (fail_q != '1) fail_q <= fail_q + 32'd1;
					end
					OP_CANCEL: begin res.status <= ST_CANCELLED; count_q <= '0; end
					default: res.status <= ST_EMPTY;
				endcase
			end
		end
	end
	assign pending = 5'(count_q);
	assign completed = ok_q;
	assign failed = fail_q;
endmodule

// ----- tb/lpq_scoreboard.sv -----
// Prefetch queue predictor and result checker.
// Depends on lpq_pkg for function and status codes.
package lpq_tb_pkg;
	import lpq_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic        kind;
		logic [31:0] id;
		logic [15:0] prio;
		logic        last;
		logic [4:0]  pending;
		logic [31:0] completed;
		logic [31:0] failed;
	} prefetch_result_t;

	typedef struct {
		logic        kind;
		logic [31:0] id;
		logic signed [15:0] prio;
	} queue_slot_t;

	class prefetch_predictor;
		bit          en = 1, auto_on = 1;
		logic [4:0]  layer_n = 2, page_n = 4, limit = 16;
		queue_slot_t slots[$];
		logic [31:0] layer_mark = 0, page_mark = 0, ok_cnt = 0, fail_cnt = 0;
		bit          layer_mark_ok = 0;
		prefetch_result_t expected_results[$];
		int          errors, checked;

		function void set_reg(logic [2:0] idx, logic [4:0] v);
			case (idx)
				CFG_ENABLE: en = v[0];
				CFG_AUTO:   auto_on = v[0];
				CFG_LAYER:  layer_n = v;
				CFG_PAGE:   page_n = v;
				CFG_LIMIT:  limit = v;
				default: ;
			endcase
		endfunction

		function void push_result(logic [2:0] st, logic k, logic [31:0] id, logic [15:0] p);
			prefetch_result_t r;
			r.status = st; r.kind = k; r.id = id; r.prio = p; r.last = 0;
			r.pending = 5'(slots.size()); r.completed = ok_cnt; r.failed = fail_cnt;
			expected_results.push_back(r);
		endfunction

		function logic [2:0] insert_request(logic k, logic [31:0] id, logic signed [15:0] p);
			int lim, pos;
			queue_slot_t s;
			if (!en) return ST_DISABLED;
			lim = (limit > 16) ? 16 : limit;
			if (slots.size() >= lim) return ST_FULL;
			pos = 0;
			while (pos < slots.size() && slots[pos].prio >= p) pos++;
			s.kind = k; s.id = id; s.prio = p;
			slots.insert(pos, s);
			return ST_QUEUED;
		endfunction

		// Notes one accepted input transfer and queues what it should produce.
		function void note_input(logic [2:0] fn, logic [31:0] id, logic signed [15:0] p,
				logic succ);
			int before_n, n;
			logic [31:0] t;
			logic [2:0] st;
			queue_slot_t s;
			before_n = expected_results.size();
			case (fn)
				FN_LAYER_START, FN_PAGE_ACCESS: begin
					n = fn[0] ? page_n : layer_n;
					if (n > 16) n = 16;
					if (en && auto_on) begin
						for (int i = 1; i <= n; i++) begin
							t = id + 32'(i);
							if (fn[0] ? (t <= page_mark) : (layer_mark_ok && t <= layer_mark))
								continue;
							st = insert_request(fn[0], t, 16'(n - i));
							if (fn[0]) page_mark = t;
							else begin
								layer_mark = t; layer_mark_ok = 1;
							end
							push_result(st, fn[0], t, 16'(n - i));
						end
					end
				end
				FN_REQ_LAYER, FN_REQ_PAGE: begin
					st = insert_request(fn[0], id, p);
					push_result(st, fn[0], id, p);
				end
				FN_DEQUEUE: begin
					if (slots.size() == 0) push_result(ST_EMPTY, 0, 0, 0);
					else begin
						s = slots[0];
						slots.delete(0);
						push_result(ST_DEQUEUED, s.kind, s.id, s.prio);
					end
				end
				FN_REPORT: begin
					if (succ) begin
						if (ok_cnt != '1) ok_cnt++;
					end else if (fail_cnt != '1) fail_cnt++;
					push_result(ST_COUNTED, 0, 0, 0);
				end
				FN_CANCEL: begin
					slots.delete();
					layer_mark = 0; layer_mark_ok = 0; page_mark = 0;
					push_result(ST_CANCELLED, 0, 0, 0);
				end
				default: ;
			endcase
			if (expected_results.size() > before_n)
				expected_results[$].last = 1;
		endfunction

		function void check_result(prefetch_result_t a);
			prefetch_result_t e;
			checked++;
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer, status %0d", a.status);
				errors++;
				return;
			end
			e = expected_results[0];
			expected_results.delete(0);
			if (a.status !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, a.status); errors++;
			end
			if (a.kind !== e.kind) begin
				$error("kind: expected %0d actual %0d", e.kind, a.kind); errors++;
			end
			if (a.id !== e.id) begin
				$error("request_id: expected %0h actual %0h", e.id, a.id); errors++;
			end
			if (a.prio !== e.prio) begin
				$error("request_priority: expected %0h actual %0h", e.prio, a.prio); errors++;
			end
			if (a.last !== e.last) begin
				$error("last: expected %0d actual %0d", e.last, a.last); errors++;
			end
			if (a.pending !== e.pending) begin
				$error("pending: expected %0d actual %0d", e.pending, a.pending); errors++;
			end
			if (a.completed !== e.completed) begin
				$error("completed: expected %0h actual %0h", e.completed, a.completed);
				errors++;
			end
			if (a.failed !== e.failed) begin
				$error("failed: expected %0h actual %0h", e.failed, a.failed); errors++;
			end
		endfunction
	endclass
endpackage

// ----- tb/tb.sv -----
// Top-level bench for the lookahead prefetch priority queue.
// Depends on lpq_pkg, lpq_tb_pkg and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lpq_pkg::*;
	import lpq_tb_pkg::*;

	localparam logic [2:0] FN_UNUSED = 3'd7;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [2:0] func = 0;
	logic [31:0] target_id = 0;
	logic signed [15:0] req_priority = 0;
	logic success = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [4:0] cfg_data = 0;
	logic out_valid, out_stall = 0;
	logic [2:0] status;
	logic kind, last;
	logic [31:0] request_id, completed, failed;
	logic signed [15:0] request_priority;
	logic [4:0] pending;

	lookahead_prefetch_priority_queue i_dut (.*);

	prefetch_predictor model = new();
	int sender_idle_pct = 0, receiver_idle_pct = 0;
	bit hold_receiver = 0;   // long receiver hold-off to back the block up
	int quiet_cycles = 0, item_count = 0;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	initial forever #5 clk = ~clk;

	// Receiver: random stall, plus a forced stretch on request.
	always @(posedge clk) begin
		if (hold_receiver) out_stall <= 1;
		else out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Result transfers are sampled at the edge, before the NBAs land.
	always @(posedge clk) begin
		prefetch_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.status = status; r.kind = kind; r.id = request_id;
			r.prio = request_priority; r.last = last; r.pending = pending;
			r.completed = completed; r.failed = failed;
			model.check_result(r);
		end
	end

	// Watchdog: cycles with no transfer on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// One input transfer; idle gaps placed before raising valid.
	task automatic send_item(logic [2:0] fn, logic [31:0] id, logic [15:0] p, logic s);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; func <= fn; target_id <= id; req_priority <= p; success <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		model.note_input(fn, id, p, s);
		item_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (model.expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);   // a lookahead with all targets skipped gives nothing back
	endtask

	task automatic write_reg(logic [2:0] idx, logic [4:0] v);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model.set_reg(idx, v);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_item();
		int sel;
		logic [2:0] fn;
		logic [31:0] id;
		sel = $urandom_range(99);
		if (sel < 25) fn = FN_LAYER_START;
		else if (sel < 45) fn = FN_PAGE_ACCESS;
		else if (sel < 55) fn = FN_REQ_LAYER;
		else if (sel < 65) fn = FN_REQ_PAGE;
		else if (sel < 85) fn = FN_DEQUEUE;
		else if (sel < 95) fn = FN_REPORT;
		else if (sel < 98) fn = FN_CANCEL;
		else fn = FN_UNUSED;
		// mostly walking ids so lookahead lands past the marks; sometimes anything
		id = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(40);
		send_item(fn, id, 16'($urandom()), 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, wrap, extremes, every operation.
		send_item(FN_DEQUEUE, 0, 0, 0);              // empty queue
		send_item(FN_PAGE_ACCESS, 0, 0, 0);          // page 0 never issued
		send_item(FN_LAYER_START, 32'hFFFF_FFFF, 0, 0); // layer wraps to 0
		send_item(FN_LAYER_START, 32'hFFFF_FFFF, 0, 0); // all skipped
		send_item(FN_REQ_LAYER, 32'hFFFF_FFFF, 16'sh7FFF, 0);
		send_item(FN_REQ_PAGE, 32'h5555_AAAA, 16'sh8000, 1);
		send_item(FN_REQ_PAGE, 32'hAAAA_5555, 16'sh8000, 0); // equal priority keeps FIFO
		send_item(FN_REPORT, 0, 0, 1);
		send_item(FN_REPORT, 0, 0, 0);
		send_item(FN_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1); // unused code
		repeat (3) send_item(FN_DEQUEUE, 0, 0, 0);
		send_item(FN_CANCEL, 0, 0, 0);
		wait_drained();
		write_reg(CFG_LAYER, 16); write_reg(CFG_PAGE, 31); write_reg(CFG_LIMIT, 31);
		send_item(FN_PAGE_ACCESS, 32'hFFFF_FFF8, 0, 0); // page wrap past the mark
		send_item(FN_LAYER_START, 5, 0, 0);          // fills to limit, rest rejected full
		send_item(FN_REQ_LAYER, 1, 0, 0);
		wait_drained();
		write_reg(CFG_ENABLE, 0);
		send_item(FN_REQ_PAGE, 3, 1, 0);             // disabled
		send_item(FN_LAYER_START, 100, 0, 0);        // suppressed
		send_item(FN_DEQUEUE, 0, 0, 0);              // dequeue ignores enable
		send_item(FN_CANCEL, 0, 0, 0);
		wait_drained();
		write_reg(CFG_ENABLE, 1); write_reg(CFG_AUTO, 0);
		send_item(FN_PAGE_ACCESS, 9, 0, 0);
		wait_drained();
		write_reg(CFG_LIMIT, 0);
		send_item(FN_REQ_LAYER, 2, 5, 0);
		wait_drained();

		// Random phases with varied settings.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				sender_idle_pct = 10; receiver_idle_pct = 53;
			end else if (ph < 4) begin
				sender_idle_pct = 53; receiver_idle_pct = 10;
			end else begin
				sender_idle_pct = 0; receiver_idle_pct = 0;
			end
			write_reg(CFG_ENABLE, 5'($urandom_range(5) != 0));
			write_reg(CFG_AUTO, 5'($urandom_range(4) != 0));
			write_reg(CFG_LAYER, (ph == 5) ? 5'd0 : 5'($urandom_range(16)));
			write_reg(CFG_PAGE, (ph == 5) ? 5'd16 : 5'($urandom_range(31)));
			write_reg(CFG_LIMIT, (ph == 1) ? 5'd4 : 5'($urandom_range(5, 31)));
			// receiver holds off for a fixed stretch while items keep coming
			if (ph == 4) fork
				begin
					hold_receiver <= 1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_receiver <= 0;
				end
			join_none
			for (int k = 0; k < 30; k++) random_item();
			wait_drained();              // sender pause until all results are back
		end

		$display("tb: %0d items sent, %0d results checked across default, extreme and",
			item_count, model.checked);
		$display("tb: random register settings with idle, stall and back-pressure phases");
		if (model.errors == 0 && model.expected_results.size() == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
